// ----- rtl/quaternion_julia_escape_test_assert.svh -----
// Assertion macros shared by the quaternion Julia escape test RTL.
`ifndef QUATERNION_JULIA_ESCAPE_TEST_ASSERT_SVH
`define QUATERNION_JULIA_ESCAPE_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QJET_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QJET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/qjet_pkg.sv -----
// Package: types, constants and the control store of the quaternion Julia escape test.
package qjet_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned COUNT_W       = 8;
  localparam int unsigned LIMIT_W       = 31;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned NUM_COMP      = 4;
  localparam int unsigned NUM_PROD      = 7;
  localparam int unsigned STEP_W        = 5;

  localparam logic signed [DATA_W-1:0] C_REAL_RST  = -32'sd7549747;
  localparam logic signed [DATA_W-1:0] C_I_RST     = -32'sd8002732;
  localparam logic signed [DATA_W-1:0] C_J_RST     = 32'sd3036676;
  localparam logic signed [DATA_W-1:0] C_K_RST     = 32'sd5133828;
  localparam logic [COUNT_W-1:0]       MAX_ITER_RST = 8'd30;
  localparam logic [LIMIT_W-1:0]       LIMIT_RST    = 31'd67108864;

  // Sequencer step addresses with a fixed meaning.
  localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
  localparam logic [STEP_W-1:0] STEP_FIRST = 5'd1;
  localparam logic [STEP_W-1:0] STEP_LOOP  = 5'd6;
  localparam logic [STEP_W-1:0] STEP_CHECK = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_REAL   = 3'd0,
    CFG_C_I      = 3'd1,
    CFG_C_J      = 3'd2,
    CFG_C_K      = 3'd3,
    CFG_MAX_ITER = 3'd4,
    CFG_LIMIT    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    Z_R = 2'd0,
    Z_I = 2'd1,
    Z_J = 2'd2,
    Z_K = 2'd3
  } zsel_e;

  typedef enum logic [2:0] {
    DST_P0 = 3'd0,
    DST_P1 = 3'd1,
    DST_P2 = 3'd2,
    DST_P3 = 3'd3,
    DST_AB = 3'd4,
    DST_AC = 3'd5,
    DST_AD = 3'd6
  } dst_e;

  typedef enum logic [2:0] {
    UOP_NONE   = 3'd0,
    UOP_WAIT   = 3'd1,
    UOP_SQUARE = 3'd2,
    UOP_ADD_C  = 3'd3,
    UOP_CHECK  = 3'd4
  } uop_e;

  typedef struct packed {
    logic              mul_en;
    logic              mul_sq;
    zsel_e             mul_sel;
    logic              wr_en;
    dst_e              wr_dst;
    uop_e              uop;
    logic [STEP_W-1:0] jump;
  } ucode_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] start_real;
    logic signed [DATA_W-1:0] start_i;
    logic signed [DATA_W-1:0] start_j;
    logic signed [DATA_W-1:0] start_k;
  } in_word_t;

  typedef struct packed {
    logic               escaped;
    logic [COUNT_W-1:0] iteration_count;
  } out_word_t;

  function automatic ucode_t uw(input logic mul_en, input logic mul_sq, input zsel_e sel,
                                input logic wr_en, input dst_e dst, input uop_e uop);
    ucode_t w;
    w.mul_en  = mul_en;
    w.mul_sq  = mul_sq;
    w.mul_sel = sel;
    w.wr_en   = wr_en;
    w.wr_dst  = dst;
    w.uop     = uop;
    w.jump    = STEP_LOOP;
    return w;
  endfunction

  // Control store. A multiply issued in one step lands in the product
  // register; the next step writes its rounded value into the bank.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      5'd0:    w = uw(1'b0, 1'b0, Z_R, 1'b0, DST_P0, UOP_WAIT);
      5'd1:    w = uw(1'b1, 1'b1, Z_R, 1'b0, DST_P0, UOP_NONE);
      5'd2:    w = uw(1'b1, 1'b1, Z_I, 1'b1, DST_P0, UOP_NONE);
      5'd3:    w = uw(1'b1, 1'b1, Z_J, 1'b1, DST_P1, UOP_NONE);
      5'd4:    w = uw(1'b1, 1'b1, Z_K, 1'b1, DST_P2, UOP_NONE);
      5'd5:    w = uw(1'b1, 1'b0, Z_I, 1'b1, DST_P3, UOP_NONE);
      5'd6:    w = uw(1'b1, 1'b0, Z_J, 1'b1, DST_AB, UOP_NONE);
      5'd7:    w = uw(1'b1, 1'b0, Z_K, 1'b1, DST_AC, UOP_NONE);
      5'd8:    w = uw(1'b0, 1'b0, Z_R, 1'b1, DST_AD, UOP_NONE);
      5'd9:    w = uw(1'b0, 1'b0, Z_R, 1'b0, DST_P0, UOP_SQUARE);
      5'd10:   w = uw(1'b0, 1'b0, Z_R, 1'b0, DST_P0, UOP_ADD_C);
      5'd11:   w = uw(1'b1, 1'b1, Z_R, 1'b0, DST_P0, UOP_NONE);
      5'd12:   w = uw(1'b1, 1'b1, Z_I, 1'b1, DST_P0, UOP_NONE);
      5'd13:   w = uw(1'b1, 1'b1, Z_J, 1'b1, DST_P1, UOP_NONE);
      5'd14:   w = uw(1'b1, 1'b1, Z_K, 1'b1, DST_P2, UOP_NONE);
      5'd15:   w = uw(1'b0, 1'b0, Z_R, 1'b1, DST_P3, UOP_NONE);
      5'd16:   w = uw(1'b1, 1'b0, Z_I, 1'b0, DST_P0, UOP_CHECK);
      default: w = uw(1'b0, 1'b0, Z_R, 1'b0, DST_P0, UOP_NONE);
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/quaternion_julia_escape_test.sv -----
// Quaternion Julia escape test: microcoded iterate-and-check of z = z*z + c.
//
//   channel | handshake              | word
//   --------+------------------------+---------------------------------------
//   in      | in_valid_i/in_ready_o  | in_word_i: start_real/i/j/k, Q7.24
//   out     | out_valid_o/out_ready_i| out_word_o: escaped, iteration_count
//   cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i selects, cfg_data_i value
//
// A 17-step control store drives one registered 32x32 multiplier. A result
// word becomes valid as the sequencer returns to idle, where the next word is
// taken; an iteration is seven multiplies, two product drains and two
// saturations, the check step issuing the last multiply.
// Reset loads the configuration defaults and parks the sequencer at idle.
// A waiting result holds the check step only if the next one is already done.
`include "quaternion_julia_escape_test_assert.svh"

module quaternion_julia_escape_test #(
  parameter int unsigned FRAC_BITS = qjet_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  qjet_pkg::in_word_t               in_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output qjet_pkg::out_word_t              out_word_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qjet_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [qjet_pkg::DATA_W-1:0]      cfg_data_i
);
  import qjet_pkg::*;

  // Rounded product drops the low FRAC_BITS bits of a 64-bit product; sums of
  // four such terms need two more bits.
  localparam int unsigned MUL_W  = 2 * DATA_W;
  localparam int unsigned PROD_W = MUL_W - FRAC_BITS;
  localparam int unsigned SUM_W  = PROD_W + 2;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = WORD_MAX;
    end else if (v < SAT_LO) begin
      r = WORD_MIN;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [DATA_W-1:0] c_q [NUM_COMP];
  logic [COUNT_W-1:0]       max_iter_q;
  logic [LIMIT_W-1:0]       limit_q;

  // Datapath registers.
  logic [STEP_W-1:0]        step_q, step_d;
  logic [COUNT_W-1:0]       count_q, count_d;
  logic signed [DATA_W-1:0] z_q [NUM_COMP];
  logic signed [MUL_W-1:0]  prod_q;
  logic signed [PROD_W-1:0] bank_q [NUM_PROD];
  logic                     out_valid_q;
  out_word_t                out_word_q;

  ucode_t                   uw_cur;
  logic                     in_fire;
  logic                     out_free;
  logic                     out_load;
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [SUM_W-1:0]  p_ext [NUM_PROD];
  logic signed [SUM_W-1:0]  sq_sum [NUM_COMP];
  logic signed [SUM_W-1:0]  add_sum [NUM_COMP];
  logic signed [SUM_W-1:0]  norm;
  logic signed [SUM_W-1:0]  limit_ext;
  logic [COUNT_W-1:0]       count_inc;
  logic                     check_stop;

  assign uw_cur      = ucode_rom(step_q);
  assign in_ready_o  = (uw_cur.uop == UOP_WAIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Multiplier operands: a square uses the selected component twice, a
  // cross term pairs it with the real part.
  assign mul_b = z_q[uw_cur.mul_sel];
  assign mul_a = uw_cur.mul_sq ? mul_b : z_q[Z_R];

  always_comb begin
    for (int p = 0; p < NUM_PROD; p++) begin
      p_ext[p] = SUM_W'(bank_q[p]);
    end
    sq_sum[Z_R] = p_ext[DST_P0] - p_ext[DST_P1] - p_ext[DST_P2] - p_ext[DST_P3];
    sq_sum[Z_I] = p_ext[DST_AB] <<< 1;
    sq_sum[Z_J] = p_ext[DST_AC] <<< 1;
    sq_sum[Z_K] = p_ext[DST_AD] <<< 1;
    for (int t = 0; t < NUM_COMP; t++) begin
      add_sum[t] = SUM_W'(z_q[t]) + SUM_W'(c_q[t]);
    end
    norm = p_ext[DST_P0] + p_ext[DST_P1] + p_ext[DST_P2] + p_ext[DST_P3];
  end

  assign limit_ext  = $signed({{(SUM_W-LIMIT_W){1'b0}}, limit_q});
  assign count_inc  = count_q + COUNT_W'(1);
  // Stop once the norm reaches the limit or the cap is hit; a zero cap
  // stops after the first pass like a cap of one.
  assign check_stop = !((norm < limit_ext) && (count_inc < max_iter_q));

  // Sequencer: advance by one step, wait at idle, branch at the check.
  always_comb begin
    step_d   = step_q;
    count_d  = count_q;
    out_load = 1'b0;
    unique case (uw_cur.uop)
      UOP_WAIT: begin
        if (in_valid_i) begin
          step_d  = STEP_FIRST;
          count_d = '0;
        end
      end
      UOP_CHECK: begin
        if (!check_stop) begin
          step_d  = uw_cur.jump;
          count_d = count_inc;
        end else if (out_free) begin
          // Hold here while the output register is still occupied.
          step_d   = STEP_IDLE;
          count_d  = count_inc;
          out_load = 1'b1;
        end
      end
      default: begin
        step_d = step_q + STEP_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_IDLE;
      count_q <= '0;
    end else begin
      step_q  <= step_d;
      count_q <= count_d;
    end
  end

  // Quaternion state: load the start point, then square and add c in place.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      z_q[Z_R] <= in_word_i.start_real;
      z_q[Z_I] <= in_word_i.start_i;
      z_q[Z_J] <= in_word_i.start_j;
      z_q[Z_K] <= in_word_i.start_k;
    end else if (uw_cur.uop == UOP_SQUARE) begin
      for (int t = 0; t < NUM_COMP; t++) begin
        z_q[t] <= sat_word(sq_sum[t]);
      end
    end else if (uw_cur.uop == UOP_ADD_C) begin
      for (int t = 0; t < NUM_COMP; t++) begin
        z_q[t] <= sat_word(add_sum[t]);
      end
    end
  end

  // Shared multiplier and the bank of floor-rounded products.
  always_ff @(posedge clk_i) begin
    if (uw_cur.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (uw_cur.wr_en) begin
      bank_q[uw_cur.wr_dst] <= prod_q[MUL_W-1:FRAC_BITS];
    end
  end

  // Output register: a finished word waits here until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q.escaped         <= (norm > limit_ext);
      out_word_q.iteration_count <= count_inc;
    end
  end

  // Configuration writes; indexes past the list drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q[Z_R]   <= C_REAL_RST;
      c_q[Z_I]   <= C_I_RST;
      c_q[Z_J]   <= C_J_RST;
      c_q[Z_K]   <= C_K_RST;
      max_iter_q <= MAX_ITER_RST;
      limit_q    <= LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_C_REAL:   c_q[Z_R]   <= cfg_data_i;
        CFG_C_I:      c_q[Z_I]   <= cfg_data_i;
        CFG_C_J:      c_q[Z_J]   <= cfg_data_i;
        CFG_C_K:      c_q[Z_K]   <= cfg_data_i;
        CFG_MAX_ITER: max_iter_q <= cfg_data_i[COUNT_W-1:0];
        CFG_LIMIT:    limit_q    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  `QJET_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_fire, step_q == STEP_FIRST, "accepted word did not start the program")
  `QJET_ASSERT_NEXT(a_result_from_check, clk_i, rst_ni, !out_valid_q && (step_q != STEP_CHECK), !out_valid_q, "result appeared outside the check step")
  `QJET_ASSERT_NEXT(a_check_holds, clk_i, rst_ni, (step_q == STEP_CHECK) && check_stop && !out_free, step_q == STEP_CHECK, "check step left while output register full")
  `QJET_ASSERT_NOW(a_count_nonzero, clk_i, rst_ni, out_valid_q, out_word_q.iteration_count != '0, "result with zero iterations")

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the quaternion Julia escape test: directed corners, then random sweeps.
module tb;
  import qjet_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;

  // Q7.24 values used by the directed words and the random generators.
  localparam logic signed [DATA_W-1:0] FX_MAX   = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] FX_MIN   = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] FX_ONE   = 32'sh0100_0000;
  localparam logic signed [DATA_W-1:0] FX_HALF  = 32'sh0080_0000;
  localparam logic signed [DATA_W-1:0] FX_TENTH = 32'sh0019_999a;
  localparam logic [DATA_W-1:0]        LIMIT_FOUR = 32'h0400_0000;

  // Indexes past the register file: writes there must leave everything alone.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_7 = 3'd7;

  localparam int SHOW_LIMIT = 10;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_word_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_word_t            out_word_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [DATA_W-1:0]    cfg_data_i  = '0;

  // Mirror of the register file, kept in step with every accepted write.
  longint             julia_c [4];
  logic [COUNT_W-1:0] iter_cap;
  logic [LIMIT_W-1:0] radius_sq;

  // Verdicts predicted for accepted points, oldest first.
  out_word_t verdict_q [$];

  int          fail_count    = 0;
  int          words_checked = 0;
  int          escapes_seen  = 0;
  int          writes_done   = 0;
  bit          steady        = 1'b0;  // set: neither side idles
  int unsigned stall_left    = 0;

  quaternion_julia_escape_test u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the iteration
  // ---------------------------------------------------------------------------

  // Exact 64-bit product, then an arithmetic shift: rounds toward minus infinity.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > longint'(FX_MAX)) return longint'(FX_MAX);
    if (v < longint'(FX_MIN)) return longint'(FX_MIN);
    return v;
  endfunction

  // Run z = z*z + c from one start point until the norm reaches the limit or
  // the count reaches the cap; at least one pass always runs, so a zero cap
  // acts like a cap of one.
  function automatic out_word_t julia_escape(input in_word_t p);
    longint      z [4];
    longint      sq [4];
    longint      norm_sq;
    int unsigned n;
    out_word_t   r;
    z[0] = longint'(signed'(p.start_real));
    z[1] = longint'(signed'(p.start_i));
    z[2] = longint'(signed'(p.start_j));
    z[3] = longint'(signed'(p.start_k));
    n = 0;
    do begin
      sq[0] = clamp32(qmul(z[0], z[0]) - qmul(z[1], z[1]) - qmul(z[2], z[2]) -
                      qmul(z[3], z[3]));
      for (int t = 1; t < 4; t++) sq[t] = clamp32(2 * qmul(z[0], z[t]));
      for (int t = 0; t < 4; t++) z[t] = clamp32(sq[t] + julia_c[t]);
      // the norm stays wide: four rounded squares, no saturation
      norm_sq = 0;
      for (int t = 0; t < 4; t++) norm_sq += qmul(z[t], z[t]);
      n++;
    end while (norm_sq < longint'(radius_sq) && n < iter_cap);
    r.escaped         = (norm_sq > longint'(radius_sq));
    r.iteration_count = n[COUNT_W-1:0];
    return r;
  endfunction

  // Mask to the register width; drop writes to unmapped indexes.
  function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [DATA_W-1:0] v);
    case (idx)
      CFG_C_REAL:   julia_c[0] = longint'(signed'(v));
      CFG_C_I:      julia_c[1] = longint'(signed'(v));
      CFG_C_J:      julia_c[2] = longint'(signed'(v));
      CFG_C_K:      julia_c[3] = longint'(signed'(v));
      CFG_MAX_ITER: iter_cap   = v[COUNT_W-1:0];
      CFG_LIMIT:    radius_sq  = v[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Random values
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, now and then a short gap, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Uniform in [-span, +span]; unsigned wrap gives the two's complement pattern.
  function automatic logic [DATA_W-1:0] fixed_within(input int unsigned span);
    return DATA_W'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic logic [DATA_W-1:0] corner_value();
    case ($urandom_range(0, 6))
      0:       return FX_MAX;
      1:       return FX_MIN;
      2:       return '0;
      3:       return 32'h0000_0001;
      4:       return 32'hffff_ffff;
      5:       return FX_ONE;
      default: return -FX_ONE;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_constant();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return fixed_within(FX_ONE);
    if (roll < 85) return $urandom();
    return corner_value();
  endfunction

  function automatic in_word_t point(input logic signed [DATA_W-1:0] re,
                                     input logic signed [DATA_W-1:0] qi,
                                     input logic signed [DATA_W-1:0] qj,
                                     input logic signed [DATA_W-1:0] qk);
    in_word_t p;
    p.start_real = re;
    p.start_i    = qi;
    p.start_j    = qj;
    p.start_k    = qk;
    return p;
  endfunction

  // Most points sit near the set so orbits run long; the rest exercise
  // saturation and every bit of the word.
  function automatic in_word_t random_point();
    int unsigned       roll;
    logic [DATA_W-1:0] v [4];
    roll = $urandom_range(0, 99);
    for (int t = 0; t < 4; t++) begin
      if (roll < 60) v[t] = fixed_within(32'h0180_0000);       // within 1.5
      else if (roll < 70) v[t] = fixed_within(32'h0001_0000);  // hugging the origin
      else if (roll < 90) v[t] = $urandom();
      else v[t] = corner_value();
    end
    return point(v[0], v[1], v[2], v[3]);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_word(input out_word_t got);
    out_word_t want;
    if (verdict_q.size() == 0) begin
      note_failure($sformatf("result word with nothing pending: escaped=%0b count=%0d",
                             got.escaped, got.iteration_count));
      return;
    end
    want = verdict_q.pop_front();
    words_checked++;
    if (got.escaped) escapes_seen++;
    if (got.escaped !== want.escaped)
      note_failure($sformatf("word %0d escaped: expected %0b, got %0b",
                             words_checked, want.escaped, got.escaped));
    if (got.iteration_count !== want.iteration_count)
      note_failure($sformatf("word %0d iteration_count: expected %0d, got %0d",
                             words_checked, want.iteration_count, got.iteration_count));
  endfunction

  // Sample results before this edge's updates land, then pick the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_word(out_word_o);
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Hold the point until it is taken, then log its verdict. Valid stays high
  // on return so the next point can follow without a bubble.
  task automatic send_point(input in_word_t p);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    verdict_q.push_back(julia_escape(p));
  endtask

  // Drop valid and wait until every pending verdict has been matched.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror_write(idx, v);
    writes_done++;
  endtask

  task automatic close_config();
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The mirror starts at the reset values, so these words also check the defaults.
  task automatic test_reset_defaults();
    send_point(point('0, '0, '0, '0));
    send_point(point(FX_MAX, FX_MAX, FX_MAX, FX_MAX));
    send_point(point(FX_MIN, FX_MIN, FX_MIN, FX_MIN));
    send_point(point(FX_MAX, FX_MIN, FX_MAX, FX_MIN));
    send_point(point(FX_TENTH, -FX_TENTH, FX_TENTH, -FX_TENTH));
    send_point(point(-FX_ONE, '0, '0, '0));
    send_point(point('0, FX_HALF, -FX_HALF, 32'sh0000_0001));
    settle();
  endtask

  // With c at zero the origin and the unit point never escape, so the count
  // lands exactly on the cap.
  task automatic test_iteration_cap();
    write_reg(CFG_C_REAL, '0);
    write_reg(CFG_C_I, '0);
    write_reg(CFG_C_J, '0);
    write_reg(CFG_C_K, '0);
    write_reg(CFG_MAX_ITER, '0);  // a zero cap still runs one pass
    close_config();
    send_point(point('0, '0, '0, '0));
    settle();
    write_reg(CFG_MAX_ITER, 32'd255);
    close_config();
    send_point(point('0, '0, '0, '0));
    send_point(point(FX_HALF, '0, '0, '0));
    settle();
    write_reg(CFG_MAX_ITER, 32'hffff_ff05);  // upper bits fall away, cap of five
    close_config();
    send_point(point('0, '0, '0, '0));
    send_point(point(FX_ONE, '0, '0, '0));
    settle();
  endtask

  task automatic test_escape_limit();
    // zero limit: one pass, escaped unless the norm is exactly zero
    write_reg(CFG_LIMIT, '0);
    close_config();
    send_point(point('0, '0, '0, '0));
    send_point(point(FX_HALF, '0, '0, '0));
    settle();
    // all ones written, top bit masked: widest limit
    write_reg(CFG_LIMIT, 32'hffff_ffff);
    close_config();
    send_point(point(FX_MAX, '0, '0, '0));
    send_point(point(FX_MIN, FX_MIN, '0, FX_MAX));
    settle();
    // norm equal to the limit stops the loop but does not count as escaped
    write_reg(CFG_LIMIT, FX_ONE);
    close_config();
    send_point(point(FX_ONE, '0, '0, '0));
    send_point(point(-FX_ONE, '0, '0, '0));
    settle();
  endtask

  task automatic test_unmapped_index();
    write_reg(CFG_UNMAPPED_6, 32'hffff_ffff);
    write_reg(CFG_UNMAPPED_7, $urandom());
    close_config();
    send_point(point(FX_HALF, '0, '0, '0));
    settle();
  endtask

  task automatic test_extreme_constant();
    write_reg(CFG_C_REAL, FX_MAX);
    write_reg(CFG_C_I, FX_MAX);
    write_reg(CFG_C_J, FX_MAX);
    write_reg(CFG_C_K, FX_MAX);
    write_reg(CFG_MAX_ITER, DATA_W'(MAX_ITER_RST));
    write_reg(CFG_LIMIT, LIMIT_FOUR);
    close_config();
    send_point(point('0, '0, '0, '0));
    send_point(point(FX_MIN, FX_MIN, FX_MIN, FX_MIN));
    settle();
    write_reg(CFG_C_REAL, FX_MIN);
    write_reg(CFG_C_I, FX_MIN);
    write_reg(CFG_C_J, FX_MIN);
    write_reg(CFG_C_K, FX_MIN);
    close_config();
    send_point(point('0, '0, '0, '0));
    settle();
  endtask

  // New settings for one phase; caps stay small so orbits stay short.
  task automatic shuffle_settings();
    int unsigned roll;
    write_reg(CFG_C_REAL, random_constant());
    write_reg(CFG_C_I, random_constant());
    write_reg(CFG_C_J, random_constant());
    write_reg(CFG_C_K, random_constant());
    roll = $urandom_range(0, 99);
    if (roll < 70) write_reg(CFG_MAX_ITER, $urandom_range(1, 30));
    else if (roll < 80) write_reg(CFG_MAX_ITER, '0);
    else if (roll < 90) write_reg(CFG_MAX_ITER, {24'($urandom()), 8'($urandom_range(1, 40))});
    else write_reg(CFG_MAX_ITER, 32'd1);
    roll = $urandom_range(0, 99);
    if (roll < 55) write_reg(CFG_LIMIT, LIMIT_FOUR);
    else if (roll < 75) write_reg(CFG_LIMIT, $urandom_range(0, 32'h1000_0000));
    else if (roll < 88) write_reg(CFG_LIMIT, $urandom());  // top bit masked
    else if (roll < 95) write_reg(CFG_LIMIT, '0);
    else write_reg(CFG_LIMIT, 32'h7fff_ffff);
    if ($urandom_range(0, 4) == 0)
      write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_6 : CFG_UNMAPPED_7, $urandom());
    close_config();
  endtask

  task automatic test_random_sweep(input int phases, input int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      settle();
      shuffle_settings();
      // every fifth phase or so runs with no idling on either side
      steady = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < per_phase; k++) send_point(random_point());
    end
    settle();
    steady = 1'b0;
  endtask

  // Full cap with c and z small: many orbits stay bounded for all 255 passes.
  task automatic test_deep_orbits(input int count);
    write_reg(CFG_C_REAL, fixed_within(FX_HALF));
    write_reg(CFG_C_I, fixed_within(FX_HALF));
    write_reg(CFG_C_J, fixed_within(FX_HALF));
    write_reg(CFG_C_K, fixed_within(FX_HALF));
    write_reg(CFG_MAX_ITER, 32'd255);
    write_reg(CFG_LIMIT, LIMIT_FOUR);
    close_config();
    for (int k = 0; k < count; k++)
      send_point(point(fixed_within(32'h0060_0000), fixed_within(32'h0060_0000),
                       fixed_within(32'h0060_0000), fixed_within(32'h0060_0000)));
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    julia_c[0] = C_REAL_RST;
    julia_c[1] = C_I_RST;
    julia_c[2] = C_J_RST;
    julia_c[3] = C_K_RST;
    iter_cap   = MAX_ITER_RST;
    radius_sq  = LIMIT_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_iteration_cap();
    test_escape_limit();
    test_unmapped_index();
    test_extreme_constant();
    test_random_sweep(24, 80);
    test_deep_orbits(24);

    // Let any stray word show up before the verdict.
    repeat (40) @(posedge clk_i);
    if (verdict_q.size() != 0)
      note_failure($sformatf("%0d verdicts never matched", verdict_q.size()));
    $display("checked %0d result words across %0d register writes", words_checked,
             writes_done);
    $display("%0d points escaped, %0d stayed bounded", escapes_seen,
             words_checked - escapes_seen);
    if (fail_count == 0) begin
      $display("[quaternion_julia_escape_test] OK");
    end else begin
      $display("[quaternion_julia_escape_test] ERROR");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("timed out with %0d verdicts pending", verdict_q.size());
    $display("[quaternion_julia_escape_test] ERROR");
    $finish;
  end

endmodule
